[design/qacm_pkg.sv]
// Package for the quadrotor attitude control mixer: field widths, register
// indexes, command/status structs shared by controller and datapath.
package qacm_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_YAW_GAIN   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ANGLE_GAIN = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_RATE_GAIN  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SPEED_LIM  = 2'd3;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_DIRECT = 2'd1;
    localparam logic [1:0] MODE_YAW    = 2'd2;
    localparam logic [1:0] MODE_FULL   = 2'd3;

    localparam logic [9:0] SPEED_LIM_RESET = 10'd800;
    localparam logic [9:0] FLOOR_CAP       = 10'd180;

    // reciprocal constants for truncating divides of 24-bit magnitudes
    localparam logic [24:0] RECIP_5   = 25'd26843546;
    localparam int unsigned SHIFT_5   = 27;
    localparam logic [24:0] RECIP_10  = 25'd26843546;
    localparam int unsigned SHIFT_10  = 28;
    localparam logic [24:0] RECIP_100 = 25'd21474837;
    localparam int unsigned SHIFT_100 = 31;

    // equation width: |15N|+|80M|+40Z stays well under 2^40
    localparam int unsigned EqW   = 42;
    localparam int unsigned RootW = 20;     // isqrt of a 40-bit value
    localparam int unsigned InW   = 152;    // packed input payload
    localparam int unsigned OutW  = 40;

    // datapath command: which phase to run
    typedef enum logic [2:0] {
        t_CMD_IDLE,
        t_CMD_LOAD,     // capture item, Z, angle/yaw errors, rate products
        t_CMD_GAIN,     // gain products
        t_CMD_PRE,      // scale L, M
        t_CMD_EQ,       // form the five motor equations
        t_CMD_ROOT,     // one iteration of shared isqrt
        t_CMD_NEXTEQ,   // store root, start next equation
        t_CMD_FINISH    // floor and clamp into output register
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] sel;    // equation being rooted
    } t_ctl;

    typedef struct packed {
        logic root_done;
    } t_sts;

endpackage

[design/qacm_ctrl.sv]
// Controller of the attitude control mixer: sequences load, equations and
// the five shared square roots. Depends on qacm_pkg.
module qacm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_free,
    input  qacm_pkg::t_sts  i_sts,
    output qacm_pkg::t_ctl  o_ctl,
    output logic            o_busy,
    output logic            o_done
);
    import qacm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_GAIN, S_PRE, S_EQ, S_ROOT, S_NEXT, S_WAIT, S_FIN
    } t_state;

    t_state     r_state;
    logic [2:0] r_sel;

    always_comb begin
        o_ctl.sel = r_sel;
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE: o_ctl.cmd = i_start ? t_CMD_LOAD : t_CMD_IDLE;
            S_GAIN: o_ctl.cmd = t_CMD_GAIN;
            S_PRE:  o_ctl.cmd = t_CMD_PRE;
            S_EQ:   o_ctl.cmd = t_CMD_EQ;
            S_ROOT: o_ctl.cmd = t_CMD_ROOT;
            S_NEXT: o_ctl.cmd = t_CMD_NEXTEQ;
            S_WAIT: o_ctl.cmd = t_CMD_IDLE;
            S_FIN: begin
                o_ctl.cmd = t_CMD_FINISH;
                o_done    = 1'b1;
            end
            default: o_ctl.cmd = t_CMD_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) r_state <= S_GAIN;
                S_GAIN: r_state <= S_PRE;
                S_PRE:  r_state <= S_EQ;
                S_EQ: begin
                    r_sel   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: if (i_sts.root_done) r_state <= S_NEXT;
                S_NEXT: begin
                    if (r_sel == 3'd4) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_sel   <= r_sel + 3'd1;
                        r_state <= S_ROOT;
                    end
                end
                S_WAIT: if (i_out_free) r_state <= S_FIN;
                S_FIN:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel <= 3'd4) else $error("equation select out of range");
    a_fin_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> r_state == S_IDLE) else $error("finish not single");
    a_root_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT && r_sel != 3'd4) |=> r_state == S_ROOT)
        else $error("root sequence broken");

endmodule

[design/qacm_dp.sv]
// Datapath of the attitude control mixer: control law, mixer equations,
// a shared restoring square root unit, floor and clamp. Depends on qacm_pkg.
module qacm_dp (
    input  logic                      i_clk,
    input  qacm_pkg::t_ctl            i_ctl,
    input  logic [qacm_pkg::InW-1:0]  i_item,
    input  logic [7:0]                i_yaw_gain,
    input  logic [7:0]                i_angle_gain,
    input  logic [7:0]                i_rate_gain,
    input  logic [9:0]                i_speed_lim,
    output qacm_pkg::t_sts            o_sts,
    output logic [qacm_pkg::OutW-1:0] o_motors
);
    import qacm_pkg::*;

    // truncating signed divide by a constant, |x| < 2^24
    function automatic logic signed [31:0] div_const(input logic signed [31:0] x,
                                                     input logic [24:0] recip,
                                                     input int unsigned sh);
        logic [23:0] mag;
        logic [48:0] prod;
        logic [23:0] q;
        mag  = x[31] ? 24'(-x) : x[23:0];
        prod = 49'(mag) * 49'(recip);
        q    = 24'(prod >> sh);
        return x[31] ? -$signed(32'(q)) : $signed(32'(q));
    endfunction

    logic [1:0]         r_mode;
    logic signed [31:0] r_z, r_l, r_m, r_n;
    logic signed [31:0] r_rdif, r_pdif, r_yerr, r_rrg, r_prg;
    logic signed [31:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [EqW-1:0] r_eq [5];
    logic [39:0]        r_rem;
    logic [RootW-1:0]   r_res;
    logic [4:0]         r_cnt;
    logic [14:0]        r_root [5];

    logic [14:0]        lift;
    logic signed [15:0] roll, pitch, yaw, rrate, prate, yrate, rang, pang;
    assign lift  = i_item[16:2];
    assign roll  = i_item[32:17];
    assign pitch = i_item[48:33];
    assign yaw   = i_item[64:49];
    assign rrate = i_item[80:65];
    assign prate = i_item[96:81];
    assign yrate = i_item[112:97];
    assign rang  = i_item[128:113];
    assign pang  = i_item[144:129];

    // load phase: angle and yaw errors, rate products
    logic signed [31:0] rdif, pdif, yerr, rrg, prg;
    always_comb begin
        rdif = 32'(roll) - div_const(32'(rang), RECIP_100, SHIFT_100);
        pdif = 32'(pitch) - div_const(32'(pang), RECIP_100, SHIFT_100);
        yerr = 32'(yaw) - div_const(32'(yrate), RECIP_10, SHIFT_10);
        rrg  = 32'(rrate) * $signed({24'd0, i_rate_gain});
        prg  = 32'(prate) * $signed({24'd0, i_rate_gain});
    end

    // gain phase: (d*150)/100 is exactly (3d)/2
    logic signed [31:0] er, ep, pa, pb, pc, pd, ny;
    always_comb begin
        er = -((r_rdif * 32'sd3) / 32'sd2);
        ep = -((r_pdif * 32'sd3) / 32'sd2);
        pa = er * $signed({24'd0, i_angle_gain});
        pb = ep * $signed({24'd0, i_angle_gain});
        pc = div_const(r_rrg, RECIP_100, SHIFT_100);
        pd = div_const(r_prg, RECIP_100, SHIFT_100);
        ny = r_yerr * $signed({24'd0, i_yaw_gain}) * 32'sd3;
    end

    logic signed [31:0] lq, mq;
    assign lq = (r_mode == MODE_FULL) ? (r_pa + r_pc) : r_l;
    assign mq = (r_mode == MODE_FULL) ? (r_pb - r_pd) : r_m;

    logic signed [EqW-1:0] ez, el, em, en;
    assign ez = EqW'(r_z) * 42'sd40;
    assign el = EqW'(r_l) * 42'sd80;
    assign em = EqW'(r_m) * 42'sd80;
    assign en = EqW'(r_n) * 42'sd15;

    logic signed [EqW-1:0] eqsel, q4;
    logic [39:0] qv;
    always_comb begin
        eqsel = r_eq[i_ctl.sel];
        q4    = eqsel / 42'sd4;
        qv    = (q4 > 0) ? q4[39:0] : 40'd0;
    end

    logic [RootW+1:0] trial;
    logic [39:0]      rem2;
    always_comb begin
        rem2  = {r_rem[37:0], qv[39 - 2*r_cnt[4:0] -: 2]};
        trial = {r_res, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            t_CMD_LOAD: begin
                r_mode <= i_item[1:0];
                r_rdif <= rdif; r_pdif <= pdif; r_yerr <= yerr;
                r_rrg  <= rrg;  r_prg  <= prg;
                r_z <= '0; r_l <= '0; r_m <= '0; r_n <= '0;
                if (i_item[1:0] == MODE_DIRECT) begin
                    r_z <= 32'(lift) * 32'sd3;
                    r_l <= div_const(-32'(roll) * 32'sd3, RECIP_5, SHIFT_5);
                    r_m <= div_const(-32'(pitch) * 32'sd3, RECIP_5, SHIFT_5);
                    r_n <= 32'(yaw) * 32'sd3;
                end else if (i_item[1] && lift != 15'd0) begin
                    r_z <= 32'(lift) * 32'sd5;
                    r_l <= 32'(roll);
                    r_m <= 32'(pitch);
                end
            end
            t_CMD_GAIN: begin
                r_pa <= pa; r_pb <= pb;
                r_pc <= pc; r_pd <= pd;
                if (r_mode[1] && r_z != 0)
                    r_n <= ny;
            end
            t_CMD_PRE: begin
                if (r_mode[1] && r_z != 0) begin
                    r_l <= div_const(lq, RECIP_5, SHIFT_5);
                    r_m <= div_const(mq, RECIP_5, SHIFT_5);
                end
            end
            t_CMD_EQ: begin
                r_eq[0] <= en - em + ez;
                r_eq[1] <= el - en + ez;
                r_eq[2] <= en + em + ez;
                r_eq[3] <= -en - el + ez;
                r_eq[4] <= ez;
                r_rem <= '0; r_res <= '0; r_cnt <= '0;
            end
            t_CMD_ROOT: begin
                if (rem2 >= 40'(trial)) begin
                    r_rem <= rem2 - 40'(trial);
                    r_res <= {r_res[RootW-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_res <= {r_res[RootW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
            end
            t_CMD_NEXTEQ: begin
                r_root[i_ctl.sel] <= (r_res > 20'd3276) ? 15'd32767
                                     : 15'(r_res * 20'd10);
                r_rem <= '0; r_res <= '0; r_cnt <= '0;
            end
            t_CMD_FINISH: begin
                for (int k = 0; k < 4; k++) begin
                    logic [14:0] v, fl;
                    fl = (r_root[4] > 15'(FLOOR_CAP)) ? 15'(FLOOR_CAP) : r_root[4];
                    v  = (r_mode == MODE_OFF) ? 15'd0
                         : ((r_root[k] < fl) ? fl : r_root[k]);
                    o_motors[k*10 +: 10] <= (v > 15'(i_speed_lim)) ? i_speed_lim
                                            : v[9:0];
                end
            end
            default: ;
        endcase
    end

    assign o_sts.root_done = (i_ctl.cmd == t_CMD_ROOT) && (r_cnt == 5'd19);

endmodule

[design/quadrotor_attitude_control_mixer.sv]
// Quadrotor attitude control mixer: one request in, four motor speeds out.
// The accept cycle loads the request and forms the error terms; then come the
// gain products, the L/M scaling, the motor equations, five square roots on
// one shared unit with a store step after each, a handoff state that waits for
// the output register to be free, and the floor/clamp step. A new request is
// accepted only once the mixer is idle again after the floor/clamp step, so one
// request is in flight at a time. The result waits in an output register
// while the next request is computed; its finish stalls until the previous
// result is taken. Depends on qacm_pkg, qacm_ctrl, qacm_dp.
module quadrotor_attitude_control_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0] lift_set[16:2] roll_set pitch_set yaw_set roll_rate
    // pitch_rate yaw_rate roll_angle pitch_angle, zero pad [151:145]
    input  logic [151:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // motor_front[9:0] motor_right[19:10] motor_back[29:20] motor_left[39:30]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import qacm_pkg::*;

    logic [7:0] r_yaw_gain, r_angle_gain, r_rate_gain;
    logic [9:0] r_speed_lim;
    logic       r_out_valid, busy, done, start;
    t_ctl       ctl;
    t_sts       sts;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_gain   <= '0;
            r_angle_gain <= '0;
            r_rate_gain  <= '0;
            r_speed_lim  <= SPEED_LIM_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_YAW_GAIN:   r_yaw_gain   <= cfg_data[7:0];
                    REG_ANGLE_GAIN: r_angle_gain <= cfg_data[7:0];
                    REG_RATE_GAIN:  r_rate_gain  <= cfg_data[7:0];
                    REG_SPEED_LIM:  r_speed_lim  <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (done)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    qacm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_out_free(!r_out_valid), .i_sts(sts), .o_ctl(ctl),
        .o_busy(busy), .o_done(done)
    );

    qacm_dp u_dp (
        .i_clk(i_clk), .i_ctl(ctl), .i_item(s_axis_tdata),
        .i_yaw_gain(r_yaw_gain), .i_angle_gain(r_angle_gain),
        .i_rate_gain(r_rate_gain), .i_speed_lim(r_speed_lim),
        .o_sts(sts), .o_motors(m_axis_tdata)
    );

endmodule

[tb/sv/quadrotor_attitude_control_mixer_tb.sv]
// Testbench for quadrotor_attitude_control_mixer: directed and random flight items
// checked field by field against an in-bench motor speed predictor.
// Depends on qacm_pkg and the mixer RTL.
module quadrotor_attitude_control_mixer_tb;
    import qacm_pkg::*;

    typedef struct {
        logic [1:0]  mode;
        logic [14:0] lift;
        logic signed [15:0] roll, pitch, yaw;
        logic signed [15:0] roll_rate, pitch_rate, yaw_rate;
        logic signed [15:0] roll_angle, pitch_angle;
    } t_flight;

    typedef struct {
        logic [9:0] front, right, back, left;
    } t_motors;

    localparam int WatchdogLimit = 4000;
    localparam int SettleCycles  = 150;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    logic [7:0] yaw_gain, angle_gain, rate_gain;
    logic [9:0] speed_lim;
    t_motors    pending_speeds[$];
    int         mismatches;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         quiet_cycles;

    quadrotor_attitude_control_mixer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint motor_root(longint x);
        longint q;
        longint r;
        q = x / 4;
        if (q <= 0) return 0;
        r = longint'(int_sqrt(q)) * 10;
        return (r > 32767) ? 32767 : r;
    endfunction

    function automatic t_motors mix_speeds(t_flight f);
        longint z, l, m, n, er, ep, fl, v;
        longint roll, pitch, yaw, lift;
        longint mot[4];
        t_motors res;
        z = 0; l = 0; m = 0; n = 0;
        lift = f.lift;
        roll = f.roll;
        pitch = f.pitch;
        yaw = f.yaw;
        for (int i = 0; i < 4; i++) mot[i] = 0;
        if (f.mode == MODE_DIRECT) begin
            z = lift * 3;
            l = (-roll * 3) / 5;
            m = (-pitch * 3) / 5;
            n = yaw * 3;
        end else if ((f.mode == MODE_YAW || f.mode == MODE_FULL) && lift != 0) begin
            z = lift * 5;
            l = roll;
            m = pitch;
            n = (yaw - longint'(f.yaw_rate) / 10) * longint'(yaw_gain) * 3;
            if (f.mode == MODE_FULL) begin
                er = -(((roll - longint'(f.roll_angle) / 100) * 150) / 100);
                ep = -(((pitch - longint'(f.pitch_angle) / 100) * 150) / 100);
                l = longint'(angle_gain) * er
                    + (longint'(rate_gain) * longint'(f.roll_rate)) / 100;
                m = longint'(angle_gain) * ep
                    - (longint'(rate_gain) * longint'(f.pitch_rate)) / 100;
            end
            l /= 5;
            m /= 5;
        end
        if (f.mode != MODE_OFF) begin
            mot[0] = motor_root(15 * n - 80 * m + 40 * z);
            mot[1] = motor_root(80 * l - 15 * n + 40 * z);
            mot[2] = motor_root(15 * n + 80 * m + 40 * z);
            mot[3] = motor_root(-15 * n - 80 * l + 40 * z);
            fl = motor_root(40 * z);
            if (fl > 180) fl = 180;
            for (int i = 0; i < 4; i++) if (mot[i] < fl) mot[i] = fl;
        end
        for (int i = 0; i < 4; i++) begin
            v = mot[i];
            if (v > longint'(speed_lim)) v = speed_lim;
            if (v < 0) v = 0;
            mot[i] = v;
        end
        res.front = mot[0][9:0];
        res.right = mot[1][9:0];
        res.back  = mot[2][9:0];
        res.left  = mot[3][9:0];
        return res;
    endfunction

    function automatic logic [151:0] pack_flight(t_flight f);
        logic [151:0] d;
        d = '0;
        d[1:0]     = f.mode;
        d[16:2]    = f.lift;
        d[32:17]   = f.roll;
        d[48:33]   = f.pitch;
        d[64:49]   = f.yaw;
        d[80:65]   = f.roll_rate;
        d[96:81]   = f.pitch_rate;
        d[112:97]  = f.yaw_rate;
        d[128:113] = f.roll_angle;
        d[144:129] = f.pitch_angle;
        return d;
    endfunction

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // send one request; valid stays high into a back-to-back request
    task automatic send_flight(t_flight f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_flight(f);
        do @(posedge i_clk); while (!s_axis_tready);
        pending_speeds.push_back(mix_speeds(f));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_YAW_GAIN:   yaw_gain   = val[7:0];
            REG_ANGLE_GAIN: angle_gain = val[7:0];
            REG_RATE_GAIN:  rate_gain  = val[7:0];
            REG_SPEED_LIM:  speed_lim  = val[9:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_gains(int yg, int ag, int rg, int ms);
        write_reg(REG_YAW_GAIN, 16'(yg));
        write_reg(REG_ANGLE_GAIN, 16'(ag));
        write_reg(REG_RATE_GAIN, 16'(rg));
        write_reg(REG_SPEED_LIM, 16'(ms));
    endtask

    function automatic t_flight make_flight(logic [1:0] md, int lift, int v);
        t_flight f;
        f.mode = md;
        f.lift = 15'(lift);
        f.roll = 16'(v); f.pitch = 16'(-v); f.yaw = 16'(v);
        f.roll_rate = 16'(v); f.pitch_rate = 16'(v); f.yaw_rate = 16'(-v);
        f.roll_angle = 16'(-v); f.pitch_angle = 16'(v);
        return f;
    endfunction

    function automatic logic [15:0] rand_axis();
        if ($urandom_range(1)) return 16'($urandom());
        return 16'($signed($urandom_range(4000)) - 2000);
    endfunction

    function automatic t_flight random_flight();
        t_flight f;
        f.mode = 2'($urandom_range(3));
        case ($urandom_range(3))
            0: f.lift = '0;
            1: f.lift = 15'($urandom());
            default: f.lift = 15'($urandom_range(3000));
        endcase
        f.roll = rand_axis(); f.pitch = rand_axis(); f.yaw = rand_axis();
        f.roll_rate = rand_axis(); f.pitch_rate = rand_axis(); f.yaw_rate = rand_axis();
        f.roll_angle = rand_axis(); f.pitch_angle = rand_axis();
        return f;
    endfunction

    task automatic test_directed_modes();
        logic [1:0] modes[4];
        modes = '{MODE_OFF, MODE_DIRECT, MODE_YAW, MODE_FULL};
        foreach (modes[i]) begin
            send_flight(make_flight(modes[i], 32767, 32767));
            send_flight(make_flight(modes[i], 0, -32768));
            send_flight(make_flight(modes[i], 1000, -100));
        end
        send_flight(make_flight(MODE_DIRECT, 1, 0));
        send_flight(make_flight(MODE_DIRECT, 0, 0));
        wait_drained();
    endtask

    // gains at full scale push the scaled roots past the 15-bit cap; then zero gains and a zero speed limit
    task automatic test_saturation();
        set_gains(255, 255, 255, 1023);
        send_flight(make_flight(MODE_FULL, 32767, 32767));
        send_flight(make_flight(MODE_FULL, 32767, -32768));
        send_flight(make_flight(MODE_YAW, 32767, -32768));
        send_flight(make_flight(MODE_YAW, 0, 32767));
        send_flight(make_flight(MODE_FULL, 0, -32768));
        wait_drained();
        set_gains(0, 0, 0, 0);
        send_flight(make_flight(MODE_DIRECT, 20000, 500));
        send_flight(make_flight(MODE_FULL, 20000, 500));
        wait_drained();
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        set_gains($urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(1023));
        repeat (count) send_flight(random_flight());
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_speeds.size() == 0) begin
                    report("unexpected result", int'(m_axis_tdata[9:0]), -1);
                end else begin
                    t_motors want;
                    want = pending_speeds.pop_front();
                    if (m_axis_tdata[9:0] !== want.front)
                        report("motor_front", m_axis_tdata[9:0], want.front);
                    if (m_axis_tdata[19:10] !== want.right)
                        report("motor_right", m_axis_tdata[19:10], want.right);
                    if (m_axis_tdata[29:20] !== want.back)
                        report("motor_back", m_axis_tdata[29:20], want.back);
                    if (m_axis_tdata[39:30] !== want.left)
                        report("motor_left", m_axis_tdata[39:30], want.left);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_YAW_GAIN;
        cfg_data      <= '0;
        quiet_cycles  = 0;
        mismatches    = 0;
        send_idle_pct = 36;
        recv_idle_pct = 48;
        yaw_gain = 0; angle_gain = 0; rate_gain = 0;
        speed_lim = SPEED_LIM_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_modes();
        test_saturation();
        test_random(270, 36, 48);
        test_random(270, 48, 36);
        test_random(270, 0, 0);

        if (pending_speeds.size() != 0)
            report("missing results", 0, pending_speeds.size());
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[sim.f]
design/qacm_pkg.sv
design/qacm_ctrl.sv
design/qacm_dp.sv
design/quadrotor_attitude_control_mixer.sv
tb/sv/quadrotor_attitude_control_mixer_tb.sv
